// File: rtl/rbst_pkg.sv
// rbst_pkg: shared types and constants for the block slot table.
// Used by every module under rtl/ except rbst_ram.
package rbst_pkg;

  localparam int SLOTS      = 4;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BLK_W      = 16;
  localparam int REF_W      = 16;
  localparam int FRAME_W    = 24;
  localparam int ACT_W      = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int PROD_W     = BLK_W + FRAME_W;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [REF_W-1:0]   REF_MAX   = {REF_W{1'b1}};
  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  localparam logic CFG_FRAMES_PER_BLOCK = 1'b0;
  localparam logic CFG_TOTAL_FRAMES     = 1'b1;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_HIT      = 3'd0,
    ACT_LOADED   = 3'd1,
    ACT_FULL     = 3'd2,
    ACT_HELD     = 3'd3,
    ACT_FREED    = 3'd4,
    ACT_NOT_RES  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [REF_W-1:0] refs;
  } slot_ent_t;

  typedef struct packed {
    logic              busy;
    logic              accept;
    logic              rd_vld;
    logic              update;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] cmp_idx;
  } seq_t;

endpackage

// File: rtl/rbst_ram.sv
// rbst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rbst_ctrl.sv
// rbst_ctrl: sequencer that walks the slots through the shared compare unit.
// Depends on rbst_pkg.
module rbst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          match,
  output rbst_pkg::seq_t seq
);
  import rbst_pkg::*;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              stop;

  assign stop = rd_vld_r && (match || (cmp_idx_r == SLOT_LAST));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SCAN;
      ST_SCAN:   if (stop) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt     = '0;
    cmp_idx_nxt = cmp_idx_r;
    rd_vld_nxt  = 1'b0;
    if (state_r == ST_SCAN) begin
      idx_nxt     = (idx_r == SLOT_LAST) ? idx_r : idx_r + 1'b1;
      cmp_idx_nxt = idx_r;
      rd_vld_nxt  = !stop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      cmp_idx_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cmp_idx_r <= cmp_idx_nxt;
      rd_vld_r  <= rd_vld_nxt;
    end
  end

  always_comb begin
    seq.busy    = (state_r != ST_IDLE);
    seq.accept  = (state_r == ST_IDLE) && start;
    seq.rd_vld  = rd_vld_r && (state_r == ST_SCAN);
    seq.update  = (state_r == ST_UPDATE);
    seq.rd_addr = idx_r;
    seq.cmp_idx = cmp_idx_r;
  end

endmodule

// File: rtl/rbst_frame.sv
// rbst_frame: frame range of a block, registered multiply then add and clamp.
// Depends on rbst_pkg.
module rbst_frame (
  input  logic                         clk,
  input  logic                         load,
  input  logic [rbst_pkg::BLK_W-1:0]   block_number,
  input  logic [rbst_pkg::FRAME_W-1:0] frames_per_block,
  input  logic [rbst_pkg::FRAME_W-1:0] total_frames,
  output logic [rbst_pkg::FRAME_W-1:0] first_frame,
  output logic [rbst_pkg::FRAME_W-1:0] end_frame
);
  import rbst_pkg::*;

  logic [PROD_W-1:0]  prod_r;
  logic [FRAME_W:0]   sum;
  logic [FRAME_W-1:0] end_sat;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(block_number) * PROD_W'(frames_per_block);
    end
  end

  always_comb begin
    first_frame = (prod_r > PROD_W'(FRAME_MAX)) ? FRAME_MAX : prod_r[FRAME_W-1:0];
    sum         = {1'b0, first_frame} + {1'b0, frames_per_block};
    end_sat     = sum[FRAME_W] ? FRAME_MAX : sum[FRAME_W-1:0];
    end_frame   = (end_sat > total_frames) ? total_frames : end_sat;
  end

endmodule

// File: rtl/refcounted_block_slot_table_core.sv
// refcounted_block_slot_table_core: top level of the reference-counted slot table.
// Depends on rbst_pkg, rbst_ctrl, rbst_ram and rbst_frame.
// After start is taken the slot scan reads one slot a cycle from the slot RAM, stops
// at the first hit or the last slot, and out_strobe is registered from the update state.
// A new item is taken only when the previous one is done; busy is high meanwhile.
// Reset (rst_n, synchronous) frees every slot and sets frames_per_block 1, total 0.
module refcounted_block_slot_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [rbst_pkg::BLK_W-1:0]      in_block_number,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [rbst_pkg::FRAME_W-1:0]    cfg_wdata,
  output logic                            out_strobe,
  output logic                            out_success,
  output logic [rbst_pkg::ACT_W-1:0]      out_action,
  output logic [rbst_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic [rbst_pkg::REF_W-1:0]      out_ref_count,
  output logic [rbst_pkg::FRAME_W-1:0]    out_first_frame,
  output logic [rbst_pkg::FRAME_W-1:0]    out_end_frame
);
  import rbst_pkg::*;

  seq_t               seq;
  logic [FRAME_W-1:0] fpb_r, total_r;
  logic               op_r;
  logic [BLK_W-1:0]   blk_r;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  slot_ent_t          rd_ent, wr_ent;
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  logic               match;
  logic               found_r;
  logic [SLOT_W-1:0]  hit_idx_r;
  logic [REF_W-1:0]   hit_refs_r;
  logic               free_any;
  logic [SLOT_W-1:0]  free_idx;
  logic [FRAME_W-1:0] first_frame, end_frame;

  logic               success;
  action_t            action;
  logic [SLOT_W-1:0]  slot;
  logic [REF_W-1:0]   refs;

  logic                  strobe_r;
  logic                  success_r;
  action_t               action_r;
  logic [SLOT_OUT_W-1:0] slot_r;
  logic [REF_W-1:0]      refs_r;
  logic [FRAME_W-1:0]    first_r, end_r;

  rbst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .match (match),
    .seq   (seq)
  );

  rbst_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ent),
    .raddr (seq.rd_addr),
    .rdata (rd_ent)
  );

  rbst_frame u_frame (
    .clk              (clk),
    .load             (seq.accept),
    .block_number     (in_block_number),
    .frames_per_block (fpb_r),
    .total_frames     (total_r),
    .first_frame      (first_frame),
    .end_frame        (end_frame)
  );

  assign busy  = seq.busy;
  assign match = seq.rd_vld && valid_r[seq.cmp_idx] && (rd_ent.blk == blk_r);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    success   = 1'b0;
    action    = ACT_NOT_RES;
    slot      = '0;
    refs      = '0;
    we        = 1'b0;
    waddr     = hit_idx_r;
    wr_ent    = '{blk: blk_r, refs: '0};
    valid_nxt = valid_r;
    if (op_r == OP_ACQUIRE) begin
      if (found_r) begin
        success = 1'b1;
        action  = ACT_HIT;
        slot    = hit_idx_r;
        refs    = (hit_refs_r == REF_MAX) ? hit_refs_r : hit_refs_r + 1'b1;
      end else if (free_any) begin
        success = 1'b1;
        action  = ACT_LOADED;
        slot    = free_idx;
        refs    = REF_W'(1);
        waddr   = free_idx;
        valid_nxt[free_idx] = 1'b1;
      end else begin
        action  = ACT_FULL;
      end
    end else if (found_r) begin
      success = 1'b1;
      slot    = hit_idx_r;
      refs    = (hit_refs_r != '0) ? hit_refs_r - 1'b1 : '0;
      if (refs == '0) begin
        action = ACT_FREED;
        valid_nxt[hit_idx_r] = 1'b0;
      end else begin
        action = ACT_HELD;
      end
    end
    wr_ent.refs = refs;
    we = seq.update && success;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpb_r    <= FRAME_W'(1);
      total_r  <= '0;
      valid_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FRAMES_PER_BLOCK: fpb_r   <= cfg_wdata;
          CFG_TOTAL_FRAMES:     total_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (seq.update) begin
        valid_r <= valid_nxt;
      end
      strobe_r <= seq.update;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.accept) begin
      op_r    <= in_opcode;
      blk_r   <= in_block_number;
      found_r <= 1'b0;
    end
    if (seq.rd_vld) begin
      found_r    <= match;
      hit_idx_r  <= seq.cmp_idx;
      hit_refs_r <= rd_ent.refs;
    end
    if (seq.update) begin
      success_r <= success;
      action_r  <= action;
      slot_r    <= SLOT_OUT_W'(slot);
      refs_r    <= refs;
      first_r   <= first_frame;
      end_r     <= end_frame;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_success     = success_r;
  assign out_action      = action_r;
  assign out_slot_index  = slot_r;
  assign out_ref_count   = refs_r;
  assign out_first_frame = first_r;
  assign out_end_frame   = end_r;

endmodule

// File: tb/tb_refcounted_block_slot_table_core.sv
// Self-checking testbench for refcounted_block_slot_table_core: directed and random
// acquire/release items through a clocked driver and monitor, checked against a predictor.
// Depends on rbst_pkg and the core RTL only.
module tb_refcounted_block_slot_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rbst_pkg::*;

  localparam int HOLD_CYC = SLOTS + 4;

  typedef enum logic [1:0] {KIND_ITEM, KIND_CFG, KIND_DRAIN} pend_kind_t;

  typedef struct {
    pend_kind_t         kind;
    logic               op;
    logic [BLK_W-1:0]   blk;
    logic               cfg_idx;
    logic [FRAME_W-1:0] cfg_val;
    int unsigned        gap_pct;
  } pend_entry_t;

  typedef struct packed {
    logic                  success;
    action_t               action;
    logic [SLOT_OUT_W-1:0] slot;
    logic [REF_W-1:0]      refs;
    logic [FRAME_W-1:0]    first_fr;
    logic [FRAME_W-1:0]    end_fr;
  } slot_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_opcode = 1'b0;
  logic [BLK_W-1:0]      in_block_number = '0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [FRAME_W-1:0]    cfg_wdata = '0;
  logic                  out_strobe;
  logic                  out_success;
  logic [ACT_W-1:0]      out_action;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic [REF_W-1:0]      out_ref_count;
  logic [FRAME_W-1:0]    out_first_frame;
  logic [FRAME_W-1:0]    out_end_frame;

  pend_entry_t  pend_q[$];
  slot_result_t slot_result_q[$];
  int unsigned  err_cnt = 0;
  int unsigned  fill_gap = 0;

  // predictor state
  logic               tbl_valid [SLOTS];
  logic [BLK_W-1:0]   tbl_blk   [SLOTS];
  logic [REF_W-1:0]   tbl_refs  [SLOTS];
  logic [FRAME_W-1:0] frames_per_blk = FRAME_W'(1);
  logic [FRAME_W-1:0] total_frame_cnt = '0;

  refcounted_block_slot_table_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_block_number (in_block_number),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_success     (out_success),
    .out_action      (out_action),
    .out_slot_index  (out_slot_index),
    .out_ref_count   (out_ref_count),
    .out_first_frame (out_first_frame),
    .out_end_frame   (out_end_frame)
  );

  function automatic slot_result_t slot_table_apply(input logic op, input logic [BLK_W-1:0] blk);
    slot_result_t r;
    int           hit;
    int           free_s;
    logic [PROD_W-1:0]  prod;
    logic [FRAME_W:0]   sum;
    r = '0;
    hit = -1;
    free_s = -1;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (tbl_valid[s] && tbl_blk[s] == blk) hit = s;
      if (!tbl_valid[s]) free_s = s;
    end
    if (op == OP_ACQUIRE) begin
      if (hit >= 0) begin
        if (tbl_refs[hit] != REF_MAX) tbl_refs[hit] = tbl_refs[hit] + 1'b1;
        r.success = 1'b1;
        r.action  = ACT_HIT;
        r.slot    = SLOT_OUT_W'(hit);
        r.refs    = tbl_refs[hit];
      end else if (free_s >= 0) begin
        tbl_valid[free_s] = 1'b1;
        tbl_blk[free_s]   = blk;
        tbl_refs[free_s]  = REF_W'(1);
        r.success = 1'b1;
        r.action  = ACT_LOADED;
        r.slot    = SLOT_OUT_W'(free_s);
        r.refs    = REF_W'(1);
      end else begin
        r.action  = ACT_FULL;
      end
    end else begin
      if (hit >= 0) begin
        if (tbl_refs[hit] != 0) tbl_refs[hit] = tbl_refs[hit] - 1'b1;
        r.success = 1'b1;
        r.slot    = SLOT_OUT_W'(hit);
        if (tbl_refs[hit] == 0) begin
          tbl_valid[hit] = 1'b0;
          r.action = ACT_FREED;
        end else begin
          r.action = ACT_HELD;
        end
        r.refs = tbl_refs[hit];
      end else begin
        r.action = ACT_NOT_RES;
      end
    end
    prod = PROD_W'(blk) * PROD_W'(frames_per_blk);
    r.first_fr = (prod > PROD_W'(FRAME_MAX)) ? FRAME_MAX : prod[FRAME_W-1:0];
    sum = {1'b0, r.first_fr} + {1'b0, frames_per_blk};
    r.end_fr = (sum > {1'b0, FRAME_MAX}) ? FRAME_MAX : sum[FRAME_W-1:0];
    if (r.end_fr > total_frame_cnt) r.end_fr = total_frame_cnt;
    return r;
  endfunction

  task automatic push_item(input logic op, input logic [BLK_W-1:0] blk);
    pend_entry_t e;
    e = '{kind: KIND_ITEM, op: op, blk: blk, cfg_idx: 1'b0, cfg_val: '0, gap_pct: fill_gap};
    pend_q = {pend_q, e};
  endtask

  task automatic push_cfg(input logic idx, input logic [FRAME_W-1:0] val);
    pend_entry_t e;
    e = '{kind: KIND_CFG, op: OP_ACQUIRE, blk: '0, cfg_idx: idx, cfg_val: val, gap_pct: 0};
    pend_q = {pend_q, e};
  endtask

  task automatic push_drain();
    pend_entry_t e;
    e = '{kind: KIND_DRAIN, op: OP_ACQUIRE, blk: '0, cfg_idx: 1'b0, cfg_val: '0, gap_pct: 0};
    pend_q = {pend_q, e};
  endtask

  // acquire/release traffic over a small block pool plus stray blocks, then release everything taken
  task automatic random_phase(input int n);
    logic [BLK_W-1:0] pool [6];
    int               acq_cnt [6];
    logic [BLK_W-1:0] stray_q[$];
    logic [BLK_W-1:0] b;
    int               k;
    int               p;
    for (int i = 0; i < 6; i++) begin
      pool[i] = BLK_W'($urandom_range(0, 65535));
      acq_cnt[i] = 0;
    end
    if ($urandom_range(0, 1)) pool[0] = '0;
    if ($urandom_range(0, 1)) pool[5] = '1;
    repeat (n) begin
      k = $urandom_range(0, 99);
      p = $urandom_range(0, 5);
      b = BLK_W'($urandom_range(0, 65535));
      if (k < 55) begin
        push_item(OP_ACQUIRE, pool[p]);
        acq_cnt[p]++;
      end else if (k < 90) begin
        push_item(OP_RELEASE, pool[p]);
      end else if (k < 95) begin
        push_item(OP_RELEASE, b);
      end else begin
        push_item(OP_ACQUIRE, b);
        stray_q = {stray_q, b};
      end
    end
    for (int i = 0; i < 6; i++) repeat (acq_cnt[i]) push_item(OP_RELEASE, pool[i]);
    foreach (stray_q[i]) push_item(OP_RELEASE, stray_q[i]);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // driver
  logic               nx_start;
  logic               nx_op;
  logic [BLK_W-1:0]   nx_blk;
  logic               nx_wr;
  logic               nx_idx;
  logic [FRAME_W-1:0] nx_wdata;
  logic               taken;
  int unsigned        quiet_cnt = 0;

  always @(posedge clk) begin
    nx_start = 1'b0;
    nx_op    = in_opcode;
    nx_blk   = in_block_number;
    nx_wr    = 1'b0;
    nx_idx   = cfg_index;
    nx_wdata = cfg_wdata;
    if (!rst_n) begin
      quiet_cnt = 0;
      frames_per_blk  = FRAME_W'(1);
      total_frame_cnt = '0;
      for (int s = 0; s < SLOTS; s++) begin
        tbl_valid[s] = 1'b0;
        tbl_blk[s]   = '0;
        tbl_refs[s]  = '0;
      end
    end else begin
      taken = start && !busy;
      if (taken) begin
        slot_result_q = {slot_result_q, slot_table_apply(in_opcode, in_block_number)};
        void'(pend_q.pop_front());
      end
      if (slot_result_q.size() == 0 && !busy && !start) quiet_cnt++;
      else quiet_cnt = 0;
      if (start && !taken) begin
        nx_start = 1'b1;
      end else if (pend_q.size() != 0) begin
        case (pend_q[0].kind)
          KIND_ITEM: begin
            if ($urandom_range(0, 99) >= pend_q[0].gap_pct) begin
              nx_start = 1'b1;
              nx_op    = pend_q[0].op;
              nx_blk   = pend_q[0].blk;
            end
          end
          KIND_CFG: begin
            if (quiet_cnt >= HOLD_CYC) begin
              nx_wr    = 1'b1;
              nx_idx   = pend_q[0].cfg_idx;
              nx_wdata = pend_q[0].cfg_val;
              if (pend_q[0].cfg_idx == CFG_FRAMES_PER_BLOCK) frames_per_blk = pend_q[0].cfg_val;
              else total_frame_cnt = pend_q[0].cfg_val;
              void'(pend_q.pop_front());
            end
          end
          default: begin
            if (quiet_cnt >= HOLD_CYC) void'(pend_q.pop_front());
          end
        endcase
      end
    end
    start           <= nx_start;
    in_opcode       <= nx_op;
    in_block_number <= nx_blk;
    cfg_wr_en       <= nx_wr;
    cfg_index       <= nx_idx;
    cfg_wdata       <= nx_wdata;
  end

  // monitor
  slot_result_t want;

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (slot_result_q.size() == 0) begin
        $display("%0t ns: result with no item outstanding, expected none, actual action %0h",
                 $time, out_action);
        err_cnt++;
      end else begin
        want = slot_result_q.pop_front();
        check_field("success", 32'(want.success), 32'(out_success));
        check_field("action", 32'(want.action), 32'(out_action));
        check_field("slot_index", 32'(want.slot), 32'(out_slot_index));
        check_field("ref_count", 32'(want.refs), 32'(out_ref_count));
        check_field("first_frame", 32'(want.first_fr), 32'(out_first_frame));
        check_field("end_frame", 32'(want.end_fr), 32'(out_end_frame));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb_refcounted_block_slot_table_core: FAIL");
    $finish;
  end

  initial begin : stim
    // directed: fill, refuse, hit, hold, free, lowest free slot, misses
    fill_gap = 0;
    push_cfg(CFG_FRAMES_PER_BLOCK, 24'd3);
    push_cfg(CFG_TOTAL_FRAMES, 24'd100);
    push_item(OP_RELEASE, 16'h0000);
    push_item(OP_ACQUIRE, 16'h0000);
    push_item(OP_ACQUIRE, 16'h0000);
    push_item(OP_ACQUIRE, 16'hFFFF);
    push_item(OP_ACQUIRE, 16'h5555);
    push_item(OP_ACQUIRE, 16'hAAAA);
    push_item(OP_ACQUIRE, 16'h1234);
    push_item(OP_RELEASE, 16'h1234);
    push_item(OP_RELEASE, 16'h5555);
    push_item(OP_ACQUIRE, 16'h00FF);
    push_item(OP_RELEASE, 16'h0000);
    push_item(OP_RELEASE, 16'h0000);
    push_item(OP_RELEASE, 16'h0000);
    push_item(OP_ACQUIRE, 16'hFF00);
    push_item(OP_RELEASE, 16'hFFFF);
    push_item(OP_RELEASE, 16'hAAAA);
    push_item(OP_RELEASE, 16'h00FF);
    push_item(OP_RELEASE, 16'hFF00);
    push_item(OP_ACQUIRE, 16'd33);
    push_item(OP_RELEASE, 16'd33);

    push_cfg(CFG_FRAMES_PER_BLOCK, FRAME_MAX);
    push_cfg(CFG_TOTAL_FRAMES, FRAME_MAX);
    random_phase(250);

    fill_gap = 46;
    push_cfg(CFG_FRAMES_PER_BLOCK, FRAME_W'($urandom_range(1, 4096)));
    push_cfg(CFG_TOTAL_FRAMES, FRAME_W'($urandom_range(0, 24'hFFFFFF)));
    random_phase(150);
    push_drain();
    random_phase(150);

    fill_gap = 33;
    push_cfg(CFG_FRAMES_PER_BLOCK, '0);
    push_cfg(CFG_TOTAL_FRAMES, '0);
    random_phase(200);

    fill_gap = 0;
    push_cfg(CFG_FRAMES_PER_BLOCK, FRAME_W'($urandom_range(1, 24'hFFFFFF)));
    push_cfg(CFG_TOTAL_FRAMES, FRAME_W'($urandom_range(0, 24'hFFFFFF)));
    random_phase(250);

    fill_gap = 33;
    push_cfg(CFG_FRAMES_PER_BLOCK, FRAME_W'($urandom_range(1, 300)));
    push_cfg(CFG_TOTAL_FRAMES, FRAME_W'($urandom_range(0, 24'hFFFFFF)));
    random_phase(200);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pend_q.size() != 0 || slot_result_q.size() != 0 || start) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_refcounted_block_slot_table_core: PASS");
    end else begin
      $display("tb_refcounted_block_slot_table_core: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rbst_pkg.sv
rtl/rbst_ram.sv
rtl/rbst_ctrl.sv
rtl/rbst_frame.sv
rtl/refcounted_block_slot_table_core.sv
tb/tb_refcounted_block_slot_table_core.sv
